[rtl/alp_pkg.sv]
// ----------------------------------------------------------------------------
// alp_pkg
// Shared types and codes for the array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package alp_pkg;

	localparam logic [4:0] CMD_APPEND     = 5'd0;
	localparam logic [4:0] CMD_INS_START  = 5'd1;
	localparam logic [4:0] CMD_INS_POS    = 5'd2;
	localparam logic [4:0] CMD_INS_AFTER  = 5'd3;
	localparam logic [4:0] CMD_INS_BEFORE = 5'd4;
	localparam logic [4:0] CMD_INS_SORTED = 5'd5;
	localparam logic [4:0] CMD_DEL_START  = 5'd6;
	localparam logic [4:0] CMD_DEL_END    = 5'd7;
	localparam logic [4:0] CMD_DEL_POS    = 5'd8;
	localparam logic [4:0] CMD_DEL_AFTER  = 5'd9;
	localparam logic [4:0] CMD_DEL_BEFORE = 5'd10;
	localparam logic [4:0] CMD_DEL_KEY    = 5'd11;
	localparam logic [4:0] CMD_DEL_ALL    = 5'd12;
	localparam logic [4:0] CMD_DEDUPE     = 5'd13;
	localparam logic [4:0] CMD_LIN_SRCH   = 5'd14;
	localparam logic [4:0] CMD_ORD_SRCH   = 5'd15;
	localparam logic [4:0] CMD_BIN_SRCH   = 5'd16;
	localparam logic [4:0] CMD_SORT       = 5'd17;
	localparam logic [4:0] CMD_DUMP       = 5'd18;
	localparam logic [4:0] CMD_DUMP_REV   = 5'd19;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_EDGE     = 3'd5;
	localparam logic [2:0] ST_UNSORTED = 3'd6;

	typedef struct packed {
		logic [4:0]         cmd;
		logic signed [31:0] value;
		logic signed [31:0] key;
		logic [4:0]         position;
	} alp_in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [3:0]         index;
		logic signed [31:0] elem_value;
		logic [4:0]         removed_count;
		logic [4:0]         length;
		logic               last;
	} alp_out_t;

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_SCAN_RD, S_SCAN_EX, S_DECIDE,
		S_INS_RD, S_INS_EX, S_INS_WR, S_DEL_RD, S_DEL_EX,
		S_SHL_RD, S_SHL_EX, S_CMP_RD, S_CMP_EX, S_DD_RD, S_DD_EX,
		S_BIN_RD, S_BIN_EX, S_SRT_RD, S_SRT_EX, S_SRJ_RD, S_SRJ_EX,
		S_SRT_WV, S_DMP_RD, S_DMP_EX, S_RESP
	} alp_state_t;

endpackage

`default_nettype wire

[rtl/alp_mem.sv]
// ----------------------------------------------------------------------------
// alp_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module alp_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/alp_ctrl.sv]
// ----------------------------------------------------------------------------
// alp_ctrl
// Command sequencer: walks the element store one read/modify/write at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module alp_ctrl #(
	parameter int CAPACITY = 16,
	parameter int CW       = 5,
	parameter int AW       = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire alp_pkg::alp_in_t req,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output alp_pkg::alp_out_t    res,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [31:0]          mem_wdata,
	output logic [AW-1:0]        mem_raddr,
	input  wire logic [31:0]     mem_rdata
);
	import alp_pkg::*;

	localparam int HW = CW + 1;

	alp_state_t state_q, state_d;

	logic [4:0]    cmd_q, pos_q;
	logic [31:0]   value_q, key_q, v_q, prev_q, rs_elem_q;
	logic [CW-1:0] cnt_q, i_q, j_q, w_q, p_q, f_q, rem_q, rs_idx_q, rs_rem_q;
	logic          found_q, unsorted_q, pset_q, rs_last_q;
	logic [2:0]    rs_st_q;
	logic signed [HW-1:0] lo_q, hi_q;

	logic          set_res, last_d;
	logic [2:0]    st_d;
	logic [CW-1:0] idx_d, rem_d, mid, daddr;
	logic [31:0]   elem_d, cur;
	logic [HW:0]   bsum;
	logic full, empty, match, gt_key, gt_val, gt_prev, gt_v, scan_stop;

	assign full    = cnt_q == CW'(CAPACITY);
	assign empty   = cnt_q == '0;
	assign match   = mem_rdata == key_q;
	assign gt_key  = $signed(mem_rdata) > $signed(key_q);
	assign gt_val  = $signed(mem_rdata) > $signed(value_q);
	assign gt_prev = $signed(prev_q) > $signed(mem_rdata);
	assign gt_v    = $signed(mem_rdata) > $signed(v_q);
	assign cur     = (cmd_q == CMD_DEL_ALL) ? key_q : v_q;
	assign bsum    = (HW+1)'(lo_q) + (HW+1)'(hi_q);
	assign mid     = CW'(bsum >> 1);
	assign daddr   = (cmd_q == CMD_DUMP) ? i_q : cnt_q - CW'(1) - i_q;
	assign scan_stop = (cmd_q == CMD_ORD_SRCH && gt_key) ||
		(cmd_q != CMD_INS_SORTED && match) ||
		(cmd_q == CMD_INS_SORTED && i_q != '0 && gt_prev);

	assign req_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_RESP;
	assign res = '{status: rs_st_q, index: 4'(rs_idx_q), elem_value: rs_elem_q,
		removed_count: 5'(rs_rem_q), length: 5'(cnt_q), last: rs_last_q};

	// next state and result
	always_comb begin
		state_d = state_q;
		set_res = 1'b0;
		st_d    = ST_OK;
		idx_d   = '0;
		elem_d  = '0;
		rem_d   = '0;
		last_d  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_START;
			end
			S_START: begin
				state_d = S_RESP;
				set_res = 1'b1;
				unique case (cmd_q)
					CMD_APPEND, CMD_INS_START, CMD_INS_POS: begin
						if (full) st_d = ST_FULL;
						else if (cmd_q == CMD_INS_POS && 32'(pos_q) > 32'(cnt_q))
							st_d = ST_BADPOS;
						else begin
							set_res = 1'b0;
							state_d = S_INS_RD;
						end
					end
					CMD_INS_AFTER, CMD_INS_BEFORE: begin
						if (full) st_d = ST_FULL;
						else begin
							set_res = 1'b0;
							state_d = S_SCAN_RD;
						end
					end
					CMD_INS_SORTED: begin
						set_res = 1'b0;
						state_d = S_SCAN_RD;
					end
					CMD_DEL_START, CMD_DEL_END, CMD_DEL_POS: begin
						if (empty) st_d = ST_EMPTY;
						else if (cmd_q == CMD_DEL_POS && 32'(pos_q) >= 32'(cnt_q))
							st_d = ST_BADPOS;
						else begin
							set_res = 1'b0;
							state_d = S_DEL_RD;
						end
					end
					CMD_DEL_AFTER, CMD_DEL_BEFORE, CMD_DEL_KEY, CMD_LIN_SRCH,
					CMD_ORD_SRCH: begin
						if (empty) st_d = ST_EMPTY;
						else begin
							set_res = 1'b0;
							state_d = S_SCAN_RD;
						end
					end
					CMD_DEL_ALL, CMD_DEDUPE, CMD_BIN_SRCH, CMD_DUMP, CMD_DUMP_REV: begin
						if (empty) st_d = ST_EMPTY;
						else begin
							set_res = 1'b0;
							if (cmd_q == CMD_DEL_ALL) state_d = S_CMP_RD;
							else if (cmd_q == CMD_DEDUPE) state_d = S_DD_RD;
							else if (cmd_q == CMD_BIN_SRCH) state_d = S_BIN_RD;
							else state_d = S_DMP_RD;
						end
					end
					CMD_SORT: begin
						set_res = 1'b0;
						state_d = S_SRT_RD;
					end
					default: st_d = ST_OK;
				endcase
			end
			S_SCAN_RD: state_d = (i_q >= cnt_q) ? S_DECIDE : S_SCAN_EX;
			S_SCAN_EX: state_d = scan_stop ? S_DECIDE : S_SCAN_RD;
			S_DECIDE: begin
				state_d = S_RESP;
				set_res = 1'b1;
				if (cmd_q == CMD_INS_SORTED) begin
					if (unsorted_q) st_d = ST_UNSORTED;
					else if (full) st_d = ST_FULL;
					else begin
						set_res = 1'b0;
						state_d = S_INS_RD;
					end
				end else if (!found_q) begin
					st_d = ST_NOTFOUND;
				end else begin
					priority case (cmd_q)
						CMD_INS_AFTER, CMD_INS_BEFORE: begin
							set_res = 1'b0;
							state_d = S_INS_RD;
						end
						CMD_DEL_AFTER: begin
							if (f_q + CW'(1) >= cnt_q) begin
								st_d  = ST_EDGE;
								idx_d = f_q;
							end else begin
								set_res = 1'b0;
								state_d = S_DEL_RD;
							end
						end
						CMD_DEL_BEFORE: begin
							if (f_q == '0) st_d = ST_EDGE;
							else begin
								set_res = 1'b0;
								state_d = S_DEL_RD;
							end
						end
						CMD_DEL_KEY: begin
							set_res = 1'b0;
							state_d = S_DEL_RD;
						end
						default: idx_d = f_q;
					endcase
				end
			end
			S_INS_RD: state_d = (j_q > p_q) ? S_INS_EX : S_INS_WR;
			S_INS_EX: state_d = S_INS_RD;
			S_INS_WR: begin
				state_d = S_RESP;
				set_res = 1'b1;
				idx_d   = p_q;
			end
			S_DEL_RD: state_d = S_DEL_EX;
			S_DEL_EX: state_d = S_SHL_RD;
			S_SHL_RD: begin
				if (j_q + CW'(1) < cnt_q) state_d = S_SHL_EX;
				else begin
					state_d = S_RESP;
					set_res = 1'b1;
					idx_d   = p_q;
					elem_d  = v_q;
				end
			end
			S_SHL_EX: state_d = S_SHL_RD;
			S_CMP_RD: begin
				if (j_q < cnt_q) state_d = S_CMP_EX;
				else if (cmd_q == CMD_DEDUPE) state_d = S_DD_RD;
				else begin
					state_d = S_RESP;
					set_res = 1'b1;
					if (j_q == w_q) st_d = ST_NOTFOUND;
					else begin
						idx_d = f_q;
						rem_d = j_q - w_q;
					end
				end
			end
			S_CMP_EX: state_d = S_CMP_RD;
			S_DD_RD: begin
				if (i_q + CW'(1) < cnt_q) state_d = S_DD_EX;
				else begin
					state_d = S_RESP;
					set_res = 1'b1;
					rem_d   = rem_q;
				end
			end
			S_DD_EX: state_d = S_CMP_RD;
			S_BIN_RD: begin
				if (lo_q <= hi_q) state_d = S_BIN_EX;
				else begin
					state_d = S_RESP;
					set_res = 1'b1;
					st_d    = ST_NOTFOUND;
				end
			end
			S_BIN_EX: begin
				if (match) begin
					state_d = S_RESP;
					set_res = 1'b1;
					idx_d   = mid;
				end else state_d = S_BIN_RD;
			end
			S_SRT_RD: begin
				if (i_q < cnt_q) state_d = S_SRT_EX;
				else begin
					state_d = S_RESP;
					set_res = 1'b1;
				end
			end
			S_SRT_EX: state_d = S_SRJ_RD;
			S_SRJ_RD: state_d = (j_q == '0) ? S_SRT_WV : S_SRJ_EX;
			S_SRJ_EX: state_d = gt_v ? S_SRJ_RD : S_SRT_WV;
			S_SRT_WV: state_d = S_SRT_RD;
			S_DMP_RD: state_d = S_DMP_EX;
			S_DMP_EX: begin
				state_d = S_RESP;
				set_res = 1'b1;
				idx_d   = daddr;
				elem_d  = mem_rdata;
				last_d  = i_q + CW'(1) == cnt_q;
			end
			S_RESP: begin
				if (res_ready) state_d = rs_last_q ? S_IDLE : S_DMP_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// store access
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = mem_rdata;
		mem_raddr = '0;
		unique case (state_q)
			S_SCAN_RD, S_DD_RD, S_SRT_RD: mem_raddr = AW'(i_q);
			S_INS_RD, S_SRJ_RD: mem_raddr = AW'(j_q - CW'(1));
			S_DEL_RD: mem_raddr = AW'(p_q);
			S_SHL_RD: mem_raddr = AW'(j_q + CW'(1));
			S_CMP_RD: mem_raddr = AW'(j_q);
			S_BIN_RD: mem_raddr = AW'(mid);
			S_DMP_RD: mem_raddr = AW'(daddr);
			S_INS_EX, S_SHL_EX: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(j_q);
			end
			S_SRJ_EX: begin
				mem_we    = gt_v;
				mem_waddr = AW'(j_q);
			end
			S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(p_q);
				mem_wdata = value_q;
			end
			S_CMP_EX: begin
				mem_we    = mem_rdata != cur;
				mem_waddr = AW'(w_q);
			end
			S_SRT_WV: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(j_q);
				mem_wdata = v_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_INS_WR: cnt_q <= cnt_q + CW'(1);
				S_SHL_RD: if (!(j_q + CW'(1) < cnt_q)) cnt_q <= cnt_q - CW'(1);
				S_CMP_RD: if (!(j_q < cnt_q)) cnt_q <= w_q;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (set_res) begin
			rs_st_q   <= st_d;
			rs_idx_q  <= idx_d;
			rs_elem_q <= elem_d;
			rs_rem_q  <= rem_d;
			rs_last_q <= last_d;
		end
		unique case (state_q)
			S_IDLE: begin
				cmd_q   <= req.cmd;
				value_q <= req.value;
				key_q   <= req.key;
				pos_q   <= req.position;
			end
			S_START: begin
				i_q        <= (cmd_q == CMD_SORT) ? CW'(1) : '0;
				j_q        <= (cmd_q == CMD_DEL_ALL) ? '0 : cnt_q;
				w_q        <= '0;
				found_q    <= 1'b0;
				unsorted_q <= 1'b0;
				pset_q     <= 1'b0;
				rem_q      <= '0;
				lo_q       <= '0;
				hi_q       <= HW'(cnt_q) - HW'(1);
				if (cmd_q == CMD_APPEND) p_q <= cnt_q;
				else if (cmd_q == CMD_DEL_END) p_q <= cnt_q - CW'(1);
				else if (cmd_q == CMD_INS_POS || cmd_q == CMD_DEL_POS) p_q <= CW'(pos_q);
				else p_q <= '0;
			end
			S_SCAN_EX: begin
				prev_q <= mem_rdata;
				if (!scan_stop) i_q <= i_q + CW'(1);
				if (cmd_q == CMD_INS_SORTED) begin
					if (i_q != '0 && gt_prev) unsorted_q <= 1'b1;
					if (!pset_q && gt_val) begin
						pset_q <= 1'b1;
						p_q    <= i_q;
					end
				end else if (match && !(cmd_q == CMD_ORD_SRCH && gt_key)) begin
					found_q <= 1'b1;
					f_q     <= i_q;
				end
			end
			S_DECIDE: begin
				priority case (cmd_q)
					CMD_INS_AFTER, CMD_DEL_AFTER: p_q <= f_q + CW'(1);
					CMD_DEL_BEFORE: p_q <= f_q - CW'(1);
					CMD_INS_SORTED: if (!pset_q) p_q <= cnt_q;
					default: p_q <= f_q;
				endcase
			end
			S_INS_EX: j_q <= j_q - CW'(1);
			S_DEL_EX: begin
				v_q <= mem_rdata;
				j_q <= p_q;
			end
			S_SHL_EX: j_q <= j_q + CW'(1);
			S_CMP_RD: begin
				if (!(j_q < cnt_q)) begin
					rem_q <= rem_q + (j_q - w_q);
					i_q   <= i_q + CW'(1);
				end
			end
			S_CMP_EX: begin
				j_q <= j_q + CW'(1);
				if (mem_rdata != cur) w_q <= w_q + CW'(1);
				else if (!found_q) begin
					found_q <= 1'b1;
					f_q     <= j_q;
				end
			end
			S_DD_EX: begin
				v_q <= mem_rdata;
				j_q <= i_q + CW'(1);
				w_q <= i_q + CW'(1);
			end
			S_BIN_EX: begin
				if (gt_key) hi_q <= HW'(mid) - HW'(1);
				else lo_q <= HW'(mid) + HW'(1);
			end
			S_SRT_EX: begin
				v_q <= mem_rdata;
				j_q <= i_q;
			end
			S_SRJ_EX: if (gt_v) j_q <= j_q - CW'(1);
			S_SRT_WV: i_q <= i_q + CW'(1);
			S_DMP_EX: i_q <= i_q + CW'(1);
			default: i_q <= i_q;
		endcase
	end

endmodule

`default_nettype wire

[rtl/array_list_engine.sv]
// ----------------------------------------------------------------------------
// array_list_engine
// Bounded list of signed words driven by one command per request beat.
// ----------------------------------------------------------------------------
// One command is taken at a time. Each element visited takes a read state on
// the single-port-read store, then a state that uses the data and may write
// back. Delete-all makes one compacting pass, dedupe makes one pass per outer
// element, and sort is an insertion sort of up to about N*N/2 element moves
// for N held entries. Dumps give one result beat per entry. Results sit in an
// output register so a new command may be taken while the last result waits.
`default_nettype none

module array_list_engine #(
	parameter int CAPACITY = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire alp_pkg::alp_in_t req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output alp_pkg::alp_out_t     rsp
);
	import alp_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	alp_out_t      res, rsp_q;
	logic          res_valid, res_ready, rsp_valid_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, mem_rdata;

	assign res_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	alp_ctrl #(.CAPACITY(CAPACITY), .CW(CW), .AW(AW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	alp_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

endmodule

`default_nettype wire
